[sv/sem_pkg.sv]
package sem_pkg;

    // Register indexes of the configuration port
    localparam logic [7:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [7:0] REG_FRAME_HEIGHT = 8'd1;

    localparam int LINE_DEPTH_DEF = 256;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);
    localparam int GRAD_W         = 11;
    localparam int SQ_W           = 18;

    // One gradient pair between front and back
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } grad_t;

    typedef struct packed {
        logic  valid;
        grad_t entry;
    } push_t;

    // Partial state of the digit-by-digit square root
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sq_t;

    // One step of the square root, working on bit pair k
    function automatic sq_t sq_step(input sq_t s, input int k);
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        sq_t             r;
        bitv  = SQ_W'(1) << (2 * k);
        trial = s.root + bitv;
        if (s.rem >= trial)
        begin
            r.rem  = s.rem - trial;
            r.root = (s.root >> 1) + bitv;
        end
        else
        begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

[sv/sem_queue.sv]
module sem_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  sem_pkg::push_t push,
    input  logic           pop,
    output sem_pkg::grad_t head,
    output logic           not_empty,
    output logic [sem_pkg::Q_CNT_W-1:0] count
);
    import sem_pkg::*;

    grad_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_pop;

    assign do_pop    = pop && (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_W'(push.valid) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

[sv/sem_front.sv]
module sem_front #(
    parameter int LINE_DEPTH = sem_pkg::LINE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  frame_width,
    input  logic [7:0]  frame_height,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  pixel,
    input  logic [sem_pkg::Q_CNT_W-1:0] q_count,
    output sem_pkg::push_t push
);
    import sem_pkg::*;

    localparam int IDX_W = $clog2(LINE_DEPTH);

    // Stage 0: position tracking
    logic [7:0]       col_reg, col_next;
    logic [8:0]       row_reg, row_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [7:0]       w, h;
    logic [8:0]       h9, h1;
    logic             abort;
    logic [7:0]       c;
    logic [8:0]       r;
    logic [IDX_W-1:0] ix;
    logic             in_frame, drop, accept;
    logic [7:0]       val;
    logic             case_a, case_b, emit;
    logic             lz, tz, bz, lst;

    // Stage 1: line store read done, window update
    logic             s1_valid_reg;
    logic             s1_emit_reg, s1_lz_reg, s1_rz_reg, s1_tz_reg, s1_bz_reg, s1_last_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [7:0]       s1_val_reg;

    logic [15:0]      mem [LINE_DEPTH];
    logic [15:0]      rd_reg;
    logic [15:0]      fwd_data_reg;
    logic             fwd_reg;
    logic [15:0]      rd;
    logic [15:0]      wr_data;

    logic [7:0]       win_reg [9];

    logic [9:0]       tl, tc, tr, ml, mr, bl, bc, br;
    logic [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;

    assign in_ready = ((Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(s1_valid_reg))
                      < (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept   = in_valid && in_ready;

    // Classify the incoming request against the frame position
    always_comb
    begin
        w        = (frame_width == 8'd0) ? 8'd1 : frame_width;
        h        = (frame_height == 8'd0) ? 8'd1 : frame_height;
        h9       = {1'b0, h};
        h1       = h9 + 9'd1;
        abort    = (col_reg >= w) || (row_reg > h1) || ((row_reg == h1) && (col_reg != 8'd0));
        c        = abort ? 8'd0 : col_reg;
        r        = abort ? 9'd0 : row_reg;
        ix       = abort ? '0 : idx_reg;
        in_frame = (r < h9);
        drop     = in_frame && kind;
        val      = in_frame ? pixel : 8'd0;
        case_a   = (c != 8'd0) && (r != 9'd0);
        case_b   = (c == 8'd0) && (r >= 9'd2);
        emit     = case_a || case_b;
        lz       = case_a ? (c == 8'd1) : (w == 8'd1);
        tz       = case_a ? (r == 9'd1) : (r == 9'd2);
        bz       = case_a ? (r >= h9) : (r >= h1);
        lst      = case_b && (r == h1);

        if (drop)
        begin
            col_next = c;
            row_next = r;
            idx_next = ix;
        end
        else if (emit && lst)
        begin
            col_next = 8'd0;
            row_next = 9'd0;
            idx_next = '0;
        end
        else if (c == w - 8'd1)
        begin
            col_next = 8'd0;
            row_next = r + 9'd1;
            idx_next = '0;
        end
        else
        begin
            col_next = c + 8'd1;
            row_next = r;
            idx_next = (ix == IDX_W'(LINE_DEPTH - 1)) ? '0 : ix + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                idx_reg <= idx_next;
            end
            s1_valid_reg <= accept && !drop;
        end
    end

    // Stage 1 payload and line store read with forwarding of the pending write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg  <= emit;
            s1_lz_reg    <= lz;
            s1_rz_reg    <= (c == 8'd0);
            s1_tz_reg    <= tz;
            s1_bz_reg    <= bz;
            s1_last_reg  <= lst;
            s1_idx_reg   <= ix;
            s1_val_reg   <= val;
            rd_reg       <= mem[ix];
            fwd_reg      <= s1_valid_reg && (s1_idx_reg == ix);
            fwd_data_reg <= wr_data;
        end
        if (s1_valid_reg)
        begin
            mem[s1_idx_reg] <= wr_data;
        end
    end

    assign rd      = fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_data = {rd[7:0], s1_val_reg};

    // 3x3 window: columns shift left, the new column enters on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]     <= win_reg[k*3 + 1];
                win_reg[k*3 + 1] <= win_reg[k*3 + 2];
            end
            win_reg[2] <= rd[15:8];
            win_reg[5] <= rd[7:0];
            win_reg[8] <= s1_val_reg;
        end
    end

    // Border masking and the two gradients
    always_comb
    begin
        tl = (s1_lz_reg || s1_tz_reg) ? 10'd0 : 10'(win_reg[1]);
        tc = s1_tz_reg ? 10'd0 : 10'(win_reg[2]);
        tr = (s1_rz_reg || s1_tz_reg) ? 10'd0 : 10'(rd[15:8]);
        ml = s1_lz_reg ? 10'd0 : 10'(win_reg[4]);
        mr = s1_rz_reg ? 10'd0 : 10'(rd[7:0]);
        bl = (s1_lz_reg || s1_bz_reg) ? 10'd0 : 10'(win_reg[7]);
        bc = s1_bz_reg ? 10'd0 : 10'(win_reg[8]);
        br = (s1_rz_reg || s1_bz_reg) ? 10'd0 : 10'(s1_val_reg);

        pos_x = GRAD_W'(bl + (bc << 1) + br);
        neg_x = GRAD_W'(tl + (tc << 1) + tr);
        pos_y = GRAD_W'(tr + (mr << 1) + br);
        neg_y = GRAD_W'(tl + (ml << 1) + bl);

        push.valid      = s1_valid_reg && s1_emit_reg;
        push.entry.gx   = signed'(pos_x - neg_x);
        push.entry.gy   = signed'(pos_y - neg_y);
        push.entry.last = s1_last_reg;
    end

endmodule

[sv/sem_back.sv]
module sem_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sem_pkg::grad_t head,
    input  logic           not_empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     magnitude,
    output logic           last
);
    import sem_pkg::*;

    localparam int N_SQ = 3;   // root stages, three bit pairs each

    logic                en;
    logic [GRAD_W-1:0]   abs_x, abs_y;

    logic                v1_reg;
    logic [7:0]          ax_reg, ay_reg;
    logic                l1_reg;

    logic                v2_reg;
    sq_t                 s2_reg;
    logic                l2_reg;

    logic                vq_reg [N_SQ];
    sq_t                 sq_reg [N_SQ];
    logic                lq_reg [N_SQ];
    sq_t                 sq_in  [N_SQ];
    sq_t                 sq_out [N_SQ];

    logic                out_valid_reg;
    logic [7:0]          mag_reg;
    logic                last_reg;

    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && not_empty;
    assign out_valid = out_valid_reg;
    assign magnitude = mag_reg;
    assign last      = last_reg;

    assign abs_x = head.gx[GRAD_W-1] ? GRAD_W'(-head.gx) : GRAD_W'(head.gx);
    assign abs_y = head.gy[GRAD_W-1] ? GRAD_W'(-head.gy) : GRAD_W'(head.gy);

    // Three root steps per stage, highest bit pair first
    always_comb
    begin
        for (int s = 0; s < N_SQ; s++)
        begin
            sq_in[s]  = (s == 0) ? s2_reg : sq_reg[s-1];
            sq_out[s] = sq_in[s];
            for (int j = 0; j < 3; j++)
            begin
                sq_out[s] = sq_step(sq_out[s], 8 - 3*s - j);
            end
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < N_SQ; s++)
            begin
                vq_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg <= not_empty;
            v2_reg <= v1_reg;
            for (int s = 0; s < N_SQ; s++)
            begin
                vq_reg[s] <= (s == 0) ? v2_reg : vq_reg[s-1];
            end
            out_valid_reg <= vq_reg[N_SQ-1];
        end
    end

    // Payload: quarter magnitudes, squares, root, saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg      <= abs_x[9:2];
            ay_reg      <= abs_y[9:2];
            l1_reg      <= head.last;
            s2_reg.rem  <= SQ_W'({8'd0, ax_reg} * {8'd0, ax_reg})
                           + SQ_W'({8'd0, ay_reg} * {8'd0, ay_reg});
            s2_reg.root <= '0;
            l2_reg      <= l1_reg;
            for (int s = 0; s < N_SQ; s++)
            begin
                sq_reg[s] <= sq_out[s];
                lq_reg[s] <= (s == 0) ? l2_reg : lq_reg[s-1];
            end
            mag_reg  <= (sq_reg[N_SQ-1].root > SQ_W'(255)) ? 8'd255
                        : sq_reg[N_SQ-1].root[7:0];
            last_reg <= lq_reg[N_SQ-1];
        end
    end

endmodule

[sv/sobel_edge_magnitude.sv]
// Sobel gradient magnitude over a raster stream of 8-bit pixels. Send the
// frame's pixels (kind 0) in raster order, then frame_width+1 drain requests
// (kind 1) to flush; results come out in raster order, one per pixel, with
// last set on the frame's bottom-right result. Pixels off the frame count as
// zero; magnitude = min(255, isqrt((|Gx|/4)^2 + (|Gy|/4)^2)). Results lag the
// input by one row plus one pixel. One request is taken per clock while the
// queue has room: the front (position tracking, one read-modify-write of the
// combined line store each request, window) feeds a four-entry queue that
// the back pipeline (abs, squares, three root stages, output register) pops.
// Set frame_width/frame_height only while the block is idle; a size change
// that leaves the position out of range restarts the frame.
module sobel_edge_magnitude #(
    parameter int LINE_DEPTH = sem_pkg::LINE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] pixel,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] magnitude,
    output logic       last
);
    import sem_pkg::*;

    logic [7:0]         width_reg, height_reg;
    logic [Q_CNT_W-1:0] q_count;
    push_t              push;
    grad_t              head;
    logic               not_empty;
    logic               pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd255;
            height_reg <= 8'd255;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sem_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .pixel        (pixel),
        .q_count      (q_count),
        .push         (push)
    );

    sem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    sem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .magnitude (magnitude),
        .last      (last)
    );

endmodule
